>>> design/assert_macros.svh
// assertion macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds from a clock edge, disabled in reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> design/hcb_pkg.sv
// package for the huffman code builder: sizes, types, state encoding
package hcb_pkg;
   localparam int LEAVES = 8;
   localparam int NODES = 2 * LEAVES - 1;
   localparam int SW = $clog2(LEAVES);
   localparam int NW = $clog2(NODES + 1);
   localparam int WW = 16;
   localparam int SLW = 20;
   localparam int LW = 3;
   localparam int CW = 7;
   localparam int PW = 22;

   typedef enum logic [2:0] {
      ST_LOAD, ST_MINIT, ST_MSCAN, ST_MWRITE, ST_WALK, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // store weight at load counter
      logic scan_init;   // start a merge search
      logic scan_step;   // examine one slot
      logic merge;       // write merge result
      logic walk_init;   // start a leaf walk
      logic walk_step;   // follow one parent link
      logic emit_done;   // result taken, advance leaf
   } cmd_type;

   typedef struct packed {
      logic load_last;   // this load fills the last slot
      logic scan_end;    // scan pointer on last slot
      logic merges_done; // current merge is the final one
      logic walk_end;    // walk reached root or the code length limit
      logic leaf_last;   // current leaf is the final one
   } status_type;
endpackage

>>> design/hcb_datapath.sv
// datapath: slot file, node links, merge search and code walk
module hcb_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  hcb_pkg::cmd_type        cmd,
   output hcb_pkg::status_type     status,
   input  logic [hcb_pkg::WW-1:0]  req_weight,
   output logic [2:0]              rsp_leaf_index,
   output logic [15:0]             rsp_leaf_weight,
   output logic [2:0]              rsp_code_length,
   output logic [6:0]              rsp_code_bits,
   output logic [21:0]             rsp_path_length_total,
   output logic                    rsp_last
);
   logic [hcb_pkg::SLW-1:0] slot_weight_ff [hcb_pkg::LEAVES];
   logic [hcb_pkg::NW-1:0]  slot_node_ff [hcb_pkg::LEAVES];
   logic [hcb_pkg::LEAVES-1:0] slot_live_ff;
   logic [hcb_pkg::NW-1:0]  node_parent_ff [hcb_pkg::NODES];
   logic [hcb_pkg::NODES-1:0] node_side_ff;
   logic [hcb_pkg::WW-1:0]  leaf_w_ff [hcb_pkg::LEAVES];
   logic [hcb_pkg::SW-1:0]  load_cnt_ff;
   logic [hcb_pkg::SW-1:0]  j_ff, k1_ff, k2_ff;
   logic                    have1_ff, have2_ff;
   logic [hcb_pkg::SW-1:0]  merge_cnt_ff;
   logic [hcb_pkg::SW-1:0]  leaf_ff;
   logic [hcb_pkg::NW-1:0]  n_ff;
   logic [hcb_pkg::LW-1:0]  len_ff;
   logic [hcb_pkg::CW-1:0]  bits_ff;
   logic [hcb_pkg::PW-1:0]  wpl_ff;
   logic [hcb_pkg::NW-1:0]  new_node;

   assign new_node = hcb_pkg::NW'(hcb_pkg::LEAVES) + hcb_pkg::NW'(merge_cnt_ff);
   assign status.load_last = load_cnt_ff == hcb_pkg::SW'(hcb_pkg::LEAVES - 1);
   assign status.scan_end = j_ff == hcb_pkg::SW'(hcb_pkg::LEAVES - 1);
   assign status.merges_done = merge_cnt_ff == hcb_pkg::SW'(hcb_pkg::LEAVES - 2);
   assign status.walk_end = (n_ff == hcb_pkg::NW'(hcb_pkg::NODES - 1))
      || (len_ff == hcb_pkg::LW'(hcb_pkg::LEAVES - 1));
   assign status.leaf_last = leaf_ff == hcb_pkg::SW'(hcb_pkg::LEAVES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         slot_live_ff <= '0;
         merge_cnt_ff <= '0;
         leaf_ff <= '0;
         wpl_ff <= '0;
      end else begin
         if (cmd.load) begin
            leaf_w_ff[load_cnt_ff] <= req_weight;
            slot_weight_ff[load_cnt_ff] <= hcb_pkg::SLW'(req_weight);
            slot_node_ff[load_cnt_ff] <= hcb_pkg::NW'(load_cnt_ff);
            slot_live_ff[load_cnt_ff] <= 1'b1;
            load_cnt_ff <= status.load_last ? '0 : load_cnt_ff + 1'b1;
            merge_cnt_ff <= '0;
            leaf_ff <= '0;
            wpl_ff <= '0;
         end
         if (cmd.scan_init) begin
            j_ff <= '0;
            have1_ff <= 1'b0;
            have2_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (!status.scan_end) j_ff <= j_ff + 1'b1;
            if (slot_live_ff[j_ff]) begin
               if (!have1_ff) begin
                  k1_ff <= j_ff;
                  have1_ff <= 1'b1;
               end else if (!have2_ff) begin
                  // second live slot, then compared against first
                  have2_ff <= 1'b1;
                  if (slot_weight_ff[j_ff] < slot_weight_ff[k1_ff]) begin
                     k2_ff <= k1_ff;
                     k1_ff <= j_ff;
                  end else begin
                     k2_ff <= j_ff;
                  end
               end else if (slot_weight_ff[j_ff] < slot_weight_ff[k1_ff]) begin
                  k2_ff <= k1_ff;
                  k1_ff <= j_ff;
               end else if (slot_weight_ff[j_ff] < slot_weight_ff[k2_ff]) begin
                  k2_ff <= j_ff;
               end
            end
         end
         if (cmd.merge) begin
            node_parent_ff[slot_node_ff[k1_ff]] <= new_node;
            node_side_ff[slot_node_ff[k1_ff]] <= 1'b0;
            node_parent_ff[slot_node_ff[k2_ff]] <= new_node;
            node_side_ff[slot_node_ff[k2_ff]] <= 1'b1;
            slot_weight_ff[k1_ff] <= slot_weight_ff[k1_ff] + slot_weight_ff[k2_ff];
            slot_node_ff[k1_ff] <= new_node;
            slot_live_ff[k2_ff] <= 1'b0;
            merge_cnt_ff <= merge_cnt_ff + 1'b1;
         end
         if (cmd.walk_init) begin
            // walk starts at the leaf that is current after this edge
            n_ff <= cmd.emit_done ? hcb_pkg::NW'(leaf_ff) + 1'b1 : hcb_pkg::NW'(leaf_ff);
            len_ff <= '0;
            bits_ff <= '0;
         end
         if (cmd.walk_step) begin
            bits_ff <= bits_ff | (hcb_pkg::CW'(node_side_ff[n_ff]) << len_ff);
            n_ff <= node_parent_ff[n_ff];
            len_ff <= len_ff + 1'b1;
         end
         if (cmd.emit_done) begin
            wpl_ff <= wpl_ff
               + hcb_pkg::PW'(leaf_w_ff[leaf_ff]) * hcb_pkg::PW'(len_ff);
            leaf_ff <= leaf_ff + 1'b1;
         end
      end
   end

   assign rsp_leaf_index = leaf_ff;
   assign rsp_leaf_weight = leaf_w_ff[leaf_ff];
   assign rsp_code_length = len_ff;
   assign rsp_code_bits = bits_ff;
   assign rsp_last = status.leaf_last;
   assign rsp_path_length_total = status.leaf_last
      ? wpl_ff + hcb_pkg::PW'(leaf_w_ff[leaf_ff]) * hcb_pkg::PW'(len_ff) : '0;
endmodule

>>> design/hcb_control.sv
// controller state machine sequencing load, merge and emit
module hcb_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  hcb_pkg::status_type  status,
   output hcb_pkg::cmd_type     cmd
);
   hcb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= hcb_pkg::ST_LOAD;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcb_pkg::ST_LOAD: begin
            if (req_valid && status.load_last) state_in = hcb_pkg::ST_MINIT;
         end
         hcb_pkg::ST_MINIT: state_in = hcb_pkg::ST_MSCAN;
         hcb_pkg::ST_MSCAN: begin
            if (status.scan_end) state_in = hcb_pkg::ST_MWRITE;
         end
         hcb_pkg::ST_MWRITE: begin
            state_in = status.merges_done ? hcb_pkg::ST_WALK : hcb_pkg::ST_MINIT;
         end
         hcb_pkg::ST_WALK: begin
            if (status.walk_end) state_in = hcb_pkg::ST_EMIT;
         end
         hcb_pkg::ST_EMIT: begin
            if (rsp_ready)
               state_in = status.leaf_last ? hcb_pkg::ST_LOAD : hcb_pkg::ST_WALK;
         end
         default: state_in = hcb_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         hcb_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         hcb_pkg::ST_MINIT: cmd.scan_init = 1'b1;
         hcb_pkg::ST_MSCAN: cmd.scan_step = 1'b1;
         hcb_pkg::ST_MWRITE: begin
            cmd.merge = 1'b1;
            cmd.walk_init = status.merges_done;
         end
         hcb_pkg::ST_WALK: cmd.walk_step = !status.walk_end;
         hcb_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_done = rsp_ready;
            cmd.walk_init = rsp_ready && !status.leaf_last;
         end
         default: cmd = '0;
      endcase
   end
endmodule

>>> design/huffman_code_builder.sv
// top level of the huffman code builder
// loading: one word per cycle while req_ready is high, LEAVES words; no result until the last word
// build: LEAVES-1 merges, each a sequential scan of all slots and then a merge write
// emit: per leaf, a parent-link walk to the root, then the output is held until taken
// synchronous active-high reset empties all slots and restarts loading
module huffman_code_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_leaf_index,
   output logic [15:0] rsp_leaf_weight,
   output logic [2:0]  rsp_code_length,
   output logic [6:0]  rsp_code_bits,
   output logic [21:0] rsp_path_length_total,
   output logic        rsp_last
);
   // command and status between controller and datapath
   hcb_pkg::cmd_type    cmd;
   hcb_pkg::status_type status;

   // sequencer
   hcb_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   // slot file, node links and walk registers
   hcb_datapath u_datapath (
      .clock, .reset, .cmd, .status, .req_weight,
      .rsp_leaf_index, .rsp_leaf_weight, .rsp_code_length, .rsp_code_bits,
      .rsp_path_length_total, .rsp_last
   );
endmodule

>>> design/hcb_checker.sv
// port-level checker for the huffman code builder, with its bind
`include "assert_macros.svh"
module hcb_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_last,
   input logic [2:0]  rsp_leaf_index,
   input logic [21:0] rsp_path_length_total
);
   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "load during emit")
   `ASSERT_CLK(a_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_leaf_index), "result dropped")
   `ASSERT_CLK(a_wpl_zero, clock, reset, (rsp_valid && !rsp_last) |-> rsp_path_length_total == 22'd0, "total on non-final")
   `ASSERT_CLK(a_after_last, clock, reset, (rsp_valid && rsp_ready && rsp_last) |=> req_ready, "no reload after last")
endmodule

bind huffman_code_builder hcb_port_checker u_hcb_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_last,
   .rsp_leaf_index, .rsp_path_length_total
);

>>> tb/sv/hcb_checker.sv
// checker for the huffman code builder: predicts codes per run and compares results
`timescale 1ns / 1ps
module hcb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_weight,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_leaf_index,
   input  logic [15:0] rsp_leaf_weight,
   input  logic [2:0]  rsp_code_length,
   input  logic [6:0]  rsp_code_bits,
   input  logic [21:0] rsp_path_length_total,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          pending_codes
);
   typedef struct packed {
      logic [2:0]  leaf_index;
      logic [15:0] leaf_weight;
      logic [2:0]  code_length;
      logic [6:0]  code_bits;
      logic [21:0] path_total;
      logic        last;
   } leaf_code_type;

   leaf_code_type code_queue[$];
   logic [15:0] leaf_w[hcb_pkg::LEAVES];
   int load_pos;

   assign pending_codes = code_queue.size();

   // build the tree from the loaded weights and queue one code per leaf
   task automatic build_codes();
      logic [hcb_pkg::SLW-1:0] sw[hcb_pkg::LEAVES];
      bit live[hcb_pkg::LEAVES];
      int snode[hcb_pkg::LEAVES];
      int parent[hcb_pkg::NODES];
      bit side[hcb_pkg::NODES];
      int k1, k2, n, len;
      logic [6:0] bits;
      longint wpl;
      leaf_code_type c;
      for (int i = 0; i < hcb_pkg::LEAVES; i++) begin
         sw[i] = hcb_pkg::SLW'(leaf_w[i]);
         live[i] = 1;
         snode[i] = i;
      end
      for (int i = 0; i < hcb_pkg::NODES; i++) begin
         parent[i] = 0;
         side[i] = 0;
      end
      for (int m = 0; m < hcb_pkg::LEAVES - 1; m++) begin
         k1 = -1;
         k2 = -1;
         for (int j = 0; j < hcb_pkg::LEAVES; j++) begin
            if (!live[j]) continue;
            if (k1 < 0) k1 = j;
            else if (k2 < 0) k2 = j;
         end
         for (int j = k2; j < hcb_pkg::LEAVES; j++) begin
            if (!live[j]) continue;
            if (sw[j] < sw[k1]) begin
               k2 = k1;
               k1 = j;
            end else if (sw[j] < sw[k2]) begin
               k2 = j;
            end
         end
         parent[snode[k1]] = hcb_pkg::LEAVES + m;
         side[snode[k1]] = 0;
         parent[snode[k2]] = hcb_pkg::LEAVES + m;
         side[snode[k2]] = 1;
         sw[k1] = sw[k1] + sw[k2];
         snode[k1] = hcb_pkg::LEAVES + m;
         live[k2] = 0;
      end
      wpl = 0;
      for (int i = 0; i < hcb_pkg::LEAVES; i++) begin
         n = i;
         len = 0;
         bits = '0;
         while (n != hcb_pkg::NODES - 1 && len < hcb_pkg::LEAVES - 1) begin
            bits[len] = side[n];
            n = parent[n];
            len++;
         end
         wpl += longint'(leaf_w[i]) * len;
         c.leaf_index = 3'(i);
         c.leaf_weight = leaf_w[i];
         c.code_length = 3'(len);
         c.code_bits = bits;
         c.path_total = (i == hcb_pkg::LEAVES - 1) ? wpl[21:0] : '0;
         c.last = (i == hcb_pkg::LEAVES - 1);
         code_queue.push_back(c);
      end
   endtask

   always @(posedge clock) begin
      leaf_code_type want, got;
      if (reset) begin
         load_pos <= 0;
         mismatch_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            leaf_w[load_pos] = req_weight;
            if (load_pos == hcb_pkg::LEAVES - 1) begin
               load_pos <= 0;
               build_codes();
            end else begin
               load_pos <= load_pos + 1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_leaf_index, rsp_leaf_weight, rsp_code_length, rsp_code_bits,
                    rsp_path_length_total, rsp_last};
            if (code_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected word: %p", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = code_queue.pop_front();
               if (want !== got) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %p actual %p", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> tb/sv/tb.sv
// testbench top for the huffman code builder: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_weight = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_leaf_index;
   logic [15:0] rsp_leaf_weight;
   logic [2:0]  rsp_code_length;
   logic [6:0]  rsp_code_bits;
   logic [21:0] rsp_path_length_total;
   logic        rsp_last;
   int          mismatch_count;
   int          pending_codes;
   bit          stim_done = 0;
   bit          hold_off = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   huffman_code_builder DUT (.*);

   hcb_checker u_checker (.*);

   // short gaps mostly, occasionally long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // directed runs first: extremes, zeros, equal weights, skewed trees
   function automatic logic [15:0] pick_weight(int item, int run_kind);
      case (run_kind)
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd7;
         3: return 16'd1 << (item % 16);
         4: return 16'hAAAA ^ {16{item[0]}};
         5: return 16'($urandom_range(0, 3));
         6: return 16'd1 << $urandom_range(0, 15);
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // valid drops only when a gap follows, so back-to-back words keep it high
   task automatic send_word(logic [15:0] w);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_weight <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      int kind;
      repeat (4) @(posedge clock);
      reset <= 0;
      // five directed runs, then random runs
      for (int r = 0; r < 54; r++) begin
         kind = (r < 3) ? r : (r < 5 ? r : (r % 2 == 0 ? $urandom_range(3, 7) : 7));
         for (int i = 0; i < hcb_pkg::LEAVES; i++) send_word(pick_weight(i, kind));
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // receiver: random stalls plus one long hold-off while words keep coming
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 99) < 70);
   end

   initial begin
      @(negedge reset);
      repeat (600) @(posedge clock);
      hold_off <= 1;
      repeat (400) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending_codes != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_codes == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: errors");
      $finish;
   end
endmodule
